/* sv/ubxfp_pkg.sv */
package ubxfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [15:0] MAX_LEN_RESET    = 16'd512;
    localparam logic        CK_ENABLE_RESET  = 1'b1;

    localparam logic [0:0] CFG_MAX_LEN   = 1'd0;
    localparam logic [0:0] CFG_CK_ENABLE = 1'd1;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BADSUM  = 2'd2;
    localparam logic [1:0] KIND_TOOLONG = 2'd3;

    typedef struct packed {
        logic [15:0] max_len;
        logic        ck_enable;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_len;
        logic [15:0] byte_index;
        logic [7:0]  byte_value;
        logic        frame_end;
    } t_result;

endpackage

/* sv/ubxfp_parser.sv */
module ubxfp_parser
    import ubxfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_beat,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK_A    = 4'd7;
    localparam logic [3:0] PH_CK_B    = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_got_a, n_got_a;

    logic [7:0]  sum_a_base;
    logic [7:0]  sum_b_base;
    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    logic        ck_ok;

    // class byte restarts the Fletcher sum
    assign sum_a_base = (r_phase == PH_CLASS) ? 8'd0 : r_sum_a;
    assign sum_b_base = (r_phase == PH_CLASS) ? 8'd0 : r_sum_b;
    assign sum_a_add  = sum_a_base + i_byte;
    assign sum_b_add  = sum_b_base + sum_a_add;
    assign len_full   = {i_byte, r_len[7:0]};
    assign count_inc  = r_count + 16'd1;
    assign ck_ok      = !i_cfg.ck_enable || ((r_got_a == r_sum_a) && (i_byte == r_sum_b));

    always_comb begin
        n_phase = r_phase;
        n_class = r_class;
        n_id    = r_id;
        n_len   = r_len;
        n_count = r_count;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_got_a = r_got_a;

        o_res_valid       = 1'b0;
        o_res.kind        = KIND_DATA;
        o_res.msg_class   = r_class;
        o_res.msg_id      = r_id;
        o_res.payload_len = r_len;
        o_res.byte_index  = 16'd0;
        o_res.byte_value  = 8'd0;
        o_res.frame_end   = 1'b0;

        if (i_beat) begin
            case (r_phase)
                PH_SYNC2: begin
                    if (i_byte == SYNC_SECOND) begin
                        n_phase = PH_CLASS;
                    end else if (i_byte != SYNC_FIRST) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_CLASS: begin
                    n_class = i_byte;
                    n_id    = 8'd0;
                    n_len   = 16'd0;
                    n_count = 16'd0;
                    n_got_a = 8'd0;
                    n_sum_a = sum_a_add;
                    n_sum_b = sum_b_add;
                    n_phase = PH_ID;
                end
                PH_ID: begin
                    n_id    = i_byte;
                    n_sum_a = sum_a_add;
                    n_sum_b = sum_b_add;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {8'd0, i_byte};
                    n_sum_a = sum_a_add;
                    n_sum_b = sum_b_add;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = len_full;
                    n_sum_a = sum_a_add;
                    n_sum_b = sum_b_add;
                    n_count = 16'd0;
                    if (len_full > i_cfg.max_len) begin
                        n_phase           = PH_HUNT;
                        o_res_valid       = 1'b1;
                        o_res.kind        = KIND_TOOLONG;
                        o_res.payload_len = len_full;
                        o_res.frame_end   = 1'b1;
                    end else if (len_full == 16'd0) begin
                        n_phase = PH_CK_A;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_sum_a          = sum_a_add;
                    n_sum_b          = sum_b_add;
                    n_count          = count_inc;
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_DATA;
                    o_res.byte_index = r_count;
                    o_res.byte_value = i_byte;
                    if (count_inc >= r_len) begin
                        n_phase = PH_CK_A;
                    end
                end
                PH_CK_A: begin
                    n_got_a = i_byte;
                    n_phase = PH_CK_B;
                end
                PH_CK_B: begin
                    n_phase         = PH_HUNT;
                    o_res_valid     = 1'b1;
                    o_res.kind      = ck_ok ? KIND_GOOD : KIND_BADSUM;
                    o_res.frame_end = 1'b1;
                end
                default: begin
                    n_phase = (i_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_class <= 8'd0;
            r_id    <= 8'd0;
            r_len   <= 16'd0;
            r_count <= 16'd0;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
            r_got_a <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_count <= n_count;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_got_a <= n_got_a;
        end
    end

endmodule

/* sv/ubx_frame_parser_top.sv */
// Output: results are registered in the output register, or in the skid entry on a stall.
// Throughput: one byte per cycle unless stalled; the parser steps on every accepted beat.
// Stalls: a sink stall parks one result in the skid entry; o_s_tready is low while it is full.
// Reset (synchronous, active low): parser hunts for sync, frame state and sums zero,
// max_payload_len = 512, checksum_enable = 1, output buffer empty.
module ubx_frame_parser_top
    import ubxfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte

    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [7:0] msg_class, [15:8] msg_id, [31:16] payload_len,
                                     // [47:32] byte_index, [55:48] byte_value
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast,   // frame_end

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    beat_in;
    logic    res_valid;
    t_result res;

    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;
    logic    r_skid_valid, n_skid_valid;
    t_result r_skid, n_skid;
    logic    drain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len   <= MAX_LEN_RESET;
            r_cfg.ck_enable <= CK_ENABLE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_LEN:   r_cfg.max_len   <= i_cfg_data;
                CFG_CK_ENABLE: r_cfg.ck_enable <= i_cfg_data[0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign o_s_tready = !r_skid_valid;
    assign beat_in    = i_s_tvalid && o_s_tready;

    ubxfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat_in),
        .i_byte      (i_s_tdata),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign drain = r_out_valid && i_m_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || drain) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out        = res;
                n_out_valid  = res_valid;
            end
        end else if (res_valid) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.byte_value, r_out.byte_index, r_out.payload_len,
                         r_out.msg_id, r_out.msg_class};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.frame_end;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser != KIND_DATA)))
        else $error("frame_end does not match result kind");

    a_status_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[55:32] == 24'd0))
        else $error("status beat carries nonzero index or value");

    a_skid_not_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_m_tready) |=> r_skid_valid)
        else $error("skid entry lost during stall");

endmodule
